// ----- sv/racp_pkg.sv -----
// Package for the animated-cursor RIFF chunk parser: item types, codes and tag tables.
package racp_pkg;

    localparam logic [2:0] ROLE_HEADER  = 3'd0;
    localparam logic [2:0] ROLE_TAG     = 3'd1;
    localparam logic [2:0] ROLE_LENGTH  = 3'd2;
    localparam logic [2:0] ROLE_LTYPE   = 3'd3;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
    localparam logic [2:0] ROLE_ERROR   = 3'd5;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_NAME   = 3'd1;
    localparam logic [2:0] KIND_ARTIST = 3'd2;
    localparam logic [2:0] KIND_ICON   = 3'd3;
    localparam logic [2:0] KIND_SEQ    = 3'd4;
    localparam logic [2:0] KIND_RATE   = 3'd5;
    localparam logic [2:0] KIND_ANIH   = 3'd6;
    localparam logic [2:0] KIND_LIST   = 3'd7;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_RIFF  = 3'd1;
    localparam logic [2:0] ERR_BAD_ACON  = 3'd2;
    localparam logic [2:0] ERR_BAD_TAG   = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    localparam logic [3:0] HDR_LEN       = 4'd12;
    localparam logic [3:0] HDR_LEN_FIRST = 4'd4;
    localparam logic [3:0] HDR_LEN_LAST  = 4'd7;
    localparam logic [3:0] ANIH_FIELDS   = 4'd9;

    localparam logic [31:0] TAG_INAM = {8'h49, 8'h4E, 8'h41, 8'h4D};
    localparam logic [31:0] TAG_IART = {8'h49, 8'h41, 8'h52, 8'h54};
    localparam logic [31:0] TAG_ICON = {8'h69, 8'h63, 8'h6F, 8'h6E};
    localparam logic [31:0] TAG_SEQ  = {8'h73, 8'h65, 8'h71, 8'h20};
    localparam logic [31:0] TAG_RATE = {8'h72, 8'h61, 8'h74, 8'h65};
    localparam logic [31:0] TAG_ANIH = {8'h61, 8'h6E, 8'h69, 8'h68};
    localparam logic [31:0] TAG_LIST = {8'h4C, 8'h49, 8'h53, 8'h54};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  role;
        logic [2:0]  chunk_kind;
        logic [7:0]  byte_out;
        logic        payload_last;
        logic [15:0] icon_number;
        logic        word_done;
        logic [31:0] word_value;
        logic [3:0]  field_index;
        logic [2:0]  error_code;
        logic        stream_end;
    } out_item_t;

    // "RIFF", length bytes (unchecked), "ACON"
    function automatic logic [7:0] hdr_magic(input logic [3:0] pos);
        logic [7:0] m;
        unique case (pos)
            4'd0:    m = 8'h52;
            4'd1:    m = 8'h49;
            4'd2:    m = 8'h46;
            4'd3:    m = 8'h46;
            4'd8:    m = 8'h41;
            4'd9:    m = 8'h43;
            4'd10:   m = 8'h4F;
            4'd11:   m = 8'h4E;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [2:0] classify_tag(input logic [31:0] t);
        logic [2:0] k;
        priority if (t == TAG_INAM) k = KIND_NAME;
        else if (t == TAG_IART)     k = KIND_ARTIST;
        else if (t == TAG_ICON)     k = KIND_ICON;
        else if (t == TAG_SEQ)      k = KIND_SEQ;
        else if (t == TAG_RATE)     k = KIND_RATE;
        else if (t == TAG_ANIH)     k = KIND_ANIH;
        else if (t == TAG_LIST)     k = KIND_LIST;
        else                        k = KIND_NONE;
        return k;
    endfunction

endpackage

// ----- sv/riff_ani_chunk_parser_unit.sv -----
// Animated-cursor RIFF chunk parser: one result item per input byte.
//
//  channel   valid          ready          payload
//  input     item_valid     item_ready     item   (racp_pkg::in_item_t)
//  output    result_valid   result_ready   result (racp_pkg::out_item_t)
//
// One byte per cycle while item_ready is high; each result is held in a register.
// The parse step is a single pass of compares and a 32-bit decrement per byte.
// A two-entry output stage (result register plus skid register) lets one more
// item in while a result is stalled; item_ready drops only when both are full.
// rst_n clears all parser state and empties the output stage at once.
module riff_ani_chunk_parser_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  racp_pkg::in_item_t   item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output racp_pkg::out_item_t  result
);

    typedef enum logic [2:0] {
        PH_HDR,
        PH_TAG,
        PH_LEN,
        PH_LTYPE,
        PH_PAY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [31:0] word_shift_reg, word_shift_next;
    logic [23:0] tag_shift_reg, tag_shift_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [2:0]  kind_reg, kind_next;
    logic [3:0]  field_count_reg, field_count_next;
    logic [15:0] icon_count_reg, icon_count_next;
    logic [2:0]  error_reg, error_next;

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    racp_pkg::out_item_t out_data_reg, out_data_next;
    racp_pkg::out_item_t skid_data_reg, skid_data_next;

    racp_pkg::out_item_t res;
    logic        item_fire, out_fire;

    logic [31:0] tag_word;
    logic [2:0]  tag_kind;
    logic [31:0] shifted_word;
    logic [31:0] remaining_dec;
    logic [3:0]  pos_hdr;
    logic [3:0]  pos_inc;
    logic [2:0]  err;
    logic [2:0]  role;
    logic [2:0]  kind;
    logic        plast;
    logic [15:0] icon;
    logic        wdone;
    logic [31:0] wval;
    logic [3:0]  fidx;
    logic        send;

    assign item_ready   = !skid_valid_reg;
    assign item_fire    = item_valid && item_ready;
    assign out_fire     = out_valid_reg && result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    assign tag_word      = {tag_shift_reg, item.data_byte};
    assign tag_kind      = racp_pkg::classify_tag(tag_word);
    assign shifted_word  = {item.data_byte, word_shift_reg[31:8]};
    assign remaining_dec = remaining_reg - 32'd1;
    assign pos_hdr       = (pos_reg > (racp_pkg::HDR_LEN - 4'd1)) ?
                           (racp_pkg::HDR_LEN - 4'd1) : pos_reg;
    assign pos_inc       = pos_reg + 4'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        word_shift_next  = word_shift_reg;
        tag_shift_next   = tag_shift_reg;
        remaining_next   = remaining_reg;
        kind_next        = kind_reg;
        field_count_next = field_count_reg;
        icon_count_next  = icon_count_reg;
        error_next       = error_reg;
        err   = racp_pkg::ERR_NONE;
        role  = racp_pkg::ROLE_HEADER;
        kind  = racp_pkg::KIND_NONE;
        plast = 1'b0;
        icon  = 16'd0;
        wdone = 1'b0;
        wval  = 32'd0;
        fidx  = 4'd0;
        send  = 1'b0;

        unique case (phase_reg)
            PH_TAG:
            begin
                role = racp_pkg::ROLE_TAG;
                tag_shift_next = tag_word[23:0];
                pos_next = pos_inc;
                if (pos_inc >= 4'd4)
                begin
                    pos_next = 4'd0;
                    if (tag_kind == racp_pkg::KIND_NONE)
                    begin
                        err = racp_pkg::ERR_BAD_TAG;
                    end
                    else
                    begin
                        kind_next = tag_kind;
                        kind = tag_kind;
                        if (tag_kind == racp_pkg::KIND_ICON)
                        begin
                            icon_count_next = icon_count_reg + 16'd1;
                            icon = icon_count_reg;
                        end
                        if (tag_kind == racp_pkg::KIND_ANIH)
                        begin
                            field_count_next = 4'd0;
                        end
                        phase_next = PH_LEN;
                    end
                end
            end
            PH_LEN:
            begin
                role = racp_pkg::ROLE_LENGTH;
                kind = kind_reg;
                if (kind_reg == racp_pkg::KIND_ICON)
                begin
                    icon = icon_count_reg - 16'd1;
                end
                word_shift_next = shifted_word;
                pos_next = pos_inc;
                if (pos_inc >= 4'd4)
                begin
                    pos_next = 4'd0;
                    wdone = 1'b1;
                    wval = shifted_word;
                    if (kind_reg == racp_pkg::KIND_LIST)
                    begin
                        phase_next = PH_LTYPE;
                    end
                    else if (shifted_word == 32'd0)
                    begin
                        remaining_next = 32'd0;
                        phase_next = PH_TAG;
                    end
                    else
                    begin
                        remaining_next = shifted_word;
                        phase_next = PH_PAY;
                    end
                end
            end
            PH_LTYPE:
            begin
                role = racp_pkg::ROLE_LTYPE;
                kind = racp_pkg::KIND_LIST;
                pos_next = pos_inc;
                if (pos_inc >= 4'd4)
                begin
                    pos_next = 4'd0;
                    phase_next = PH_TAG;
                end
            end
            PH_PAY:
            begin
                role = racp_pkg::ROLE_PAYLOAD;
                kind = kind_reg;
                if (kind_reg == racp_pkg::KIND_ICON)
                begin
                    icon = icon_count_reg - 16'd1;
                end
                remaining_next = remaining_dec;
                if (kind_reg == racp_pkg::KIND_ANIH)
                begin
                    word_shift_next = shifted_word;
                    pos_next = {2'b00, pos_inc[1:0]};
                    if (pos_inc[1:0] == 2'd0 && field_count_reg < racp_pkg::ANIH_FIELDS)
                    begin
                        field_count_next = field_count_reg + 4'd1;
                        wdone = 1'b1;
                        wval = shifted_word;
                        fidx = field_count_reg + 4'd1;
                    end
                end
                if (remaining_dec == 32'd0)
                begin
                    plast = 1'b1;
                    pos_next = 4'd0;
                    phase_next = PH_TAG;
                end
            end
            default:
            begin
                phase_next = PH_HDR;
                role = racp_pkg::ROLE_HEADER;
                if (pos_hdr >= racp_pkg::HDR_LEN_FIRST && pos_hdr <= racp_pkg::HDR_LEN_LAST)
                begin
                    word_shift_next = shifted_word;
                    if (pos_hdr == racp_pkg::HDR_LEN_LAST)
                    begin
                        wdone = 1'b1;
                        wval = shifted_word;
                    end
                end
                else if (item.data_byte != racp_pkg::hdr_magic(pos_hdr))
                begin
                    err = (pos_hdr < racp_pkg::HDR_LEN_FIRST) ?
                          racp_pkg::ERR_BAD_RIFF : racp_pkg::ERR_BAD_ACON;
                end
                pos_next = pos_hdr + 4'd1;
                if (pos_next >= racp_pkg::HDR_LEN)
                begin
                    pos_next = 4'd0;
                    phase_next = PH_TAG;
                end
            end
        endcase

        if (err == racp_pkg::ERR_NONE && item.end_of_data)
        begin
            if (phase_next == PH_TAG && pos_next == 4'd0)
            begin
                send = 1'b1;
                phase_next       = PH_HDR;
                pos_next         = 4'd0;
                word_shift_next  = 32'd0;
                tag_shift_next   = 24'd0;
                remaining_next   = 32'd0;
                kind_next        = racp_pkg::KIND_NONE;
                field_count_next = 4'd0;
                icon_count_next  = 16'd0;
            end
            else
            begin
                err = racp_pkg::ERR_TRUNCATED;
            end
        end

        // latched error: state frozen, every item gets the error answer
        if (error_reg != racp_pkg::ERR_NONE)
        begin
            phase_next       = phase_reg;
            pos_next         = pos_reg;
            word_shift_next  = word_shift_reg;
            tag_shift_next   = tag_shift_reg;
            remaining_next   = remaining_reg;
            kind_next        = kind_reg;
            field_count_next = field_count_reg;
            icon_count_next  = icon_count_reg;
            err = error_reg;
        end
        error_next = err;

        res = '0;
        res.byte_out = item.data_byte;
        if (err != racp_pkg::ERR_NONE)
        begin
            res.role       = racp_pkg::ROLE_ERROR;
            res.error_code = err;
        end
        else
        begin
            res.role         = role;
            res.chunk_kind   = kind;
            res.payload_last = plast;
            res.icon_number  = icon;
            res.word_done    = wdone;
            res.word_value   = wval;
            res.field_index  = fidx;
            res.stream_end   = send;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_fire)
        begin
            out_valid_next  = skid_valid_reg;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (item_fire)
        begin
            if (out_valid_reg && !result_ready)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR;
            pos_reg         <= 4'd0;
            word_shift_reg  <= 32'd0;
            tag_shift_reg   <= 24'd0;
            remaining_reg   <= 32'd0;
            kind_reg        <= racp_pkg::KIND_NONE;
            field_count_reg <= 4'd0;
            icon_count_reg  <= 16'd0;
            error_reg       <= racp_pkg::ERR_NONE;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item_fire)
            begin
                phase_reg       <= phase_next;
                pos_reg         <= pos_next;
                word_shift_reg  <= word_shift_next;
                tag_shift_reg   <= tag_shift_next;
                remaining_reg   <= remaining_next;
                kind_reg        <= kind_next;
                field_count_reg <= field_count_next;
                icon_count_reg  <= icon_count_next;
                error_reg       <= error_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ----- bench/riff_ani_chunk_parser_checker.sv -----
// Checker for the RIFF chunk parser: per-byte prediction and in-order comparison of result items.
module riff_ani_chunk_parser_checker
    import racp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      item_ready,
    input  in_item_t  item,
    input  logic      result_valid,
    input  logic      result_ready,
    input  out_item_t result,
    output int        failures,
    output int        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] RIFF_ID = 32'h5249_4646;
    localparam logic [31:0] ACON_ID = 32'h4143_4F4E;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TAG,
        PH_LENGTH,
        PH_LTYPE,
        PH_PAYLOAD
    } parse_phase_t;

    parse_phase_t phase;
    logic [3:0]   pos;
    logic [31:0]  word_sr;
    logic [31:0]  tag_sr;
    logic [31:0]  remaining;
    logic [2:0]   kind_now;
    logic [3:0]   anih_fields;
    logic [15:0]  icons;
    logic [2:0]   err_latched;

    out_item_t tagged_due[$];

    function automatic void clear_parser();
        phase       = PH_HEADER;
        pos         = '0;
        word_sr     = '0;
        tag_sr      = '0;
        remaining   = '0;
        kind_now    = KIND_NONE;
        anih_fields = '0;
        icons       = '0;
        err_latched = ERR_NONE;
    endfunction

    function automatic logic [2:0] kind_of_tag(input logic [31:0] t);
        case (t)
            TAG_INAM: return KIND_NAME;
            TAG_IART: return KIND_ARTIST;
            TAG_ICON: return KIND_ICON;
            TAG_SEQ:  return KIND_SEQ;
            TAG_RATE: return KIND_RATE;
            TAG_ANIH: return KIND_ANIH;
            TAG_LIST: return KIND_LIST;
            default:  return KIND_NONE;
        endcase
    endfunction

    function automatic logic [7:0] magic_at(input logic [3:0] p);
        if (p < HDR_LEN_FIRST)
            return RIFF_ID[31 - 8 * p -: 8];
        return ACON_ID[31 - 8 * (p - 8) -: 8];
    endfunction

    task automatic tag_byte(input in_item_t it, output out_item_t r);
        logic [2:0] err;
        logic [3:0] p;
        logic [2:0] k;
        r = '0;
        r.byte_out = it.data_byte;
        if (err_latched != ERR_NONE)
        begin
            r.role       = ROLE_ERROR;
            r.error_code = err_latched;
            return;
        end
        err = ERR_NONE;
        p   = pos;
        case (phase)
            PH_TAG:
            begin
                r.role = ROLE_TAG;
                tag_sr = {tag_sr[23:0], it.data_byte};
                p      = p + 4'd1;
                if (p >= 4'd4)
                begin
                    k = kind_of_tag(tag_sr);
                    p = '0;
                    if (k == KIND_NONE)
                        err = ERR_BAD_TAG;
                    else
                    begin
                        kind_now     = k;
                        r.chunk_kind = k;
                        if (k == KIND_ICON)
                        begin
                            r.icon_number = icons;
                            icons         = icons + 16'd1;
                        end
                        if (k == KIND_ANIH)
                            anih_fields = '0;
                        phase = PH_LENGTH;
                    end
                end
            end
            PH_LENGTH:
            begin
                r.role       = ROLE_LENGTH;
                r.chunk_kind = kind_now;
                if (kind_now == KIND_ICON)
                    r.icon_number = icons - 16'd1;
                word_sr = {it.data_byte, word_sr[31:8]};
                p       = p + 4'd1;
                if (p >= 4'd4)
                begin
                    p            = '0;
                    r.word_done  = 1'b1;
                    r.word_value = word_sr;
                    if (kind_now == KIND_LIST)
                        phase = PH_LTYPE;
                    else if (word_sr == '0)
                    begin
                        remaining = '0;
                        phase     = PH_TAG;
                    end
                    else
                    begin
                        remaining = word_sr;
                        phase     = PH_PAYLOAD;
                    end
                end
            end
            PH_LTYPE:
            begin
                r.role       = ROLE_LTYPE;
                r.chunk_kind = KIND_LIST;
                p            = p + 4'd1;
                if (p >= 4'd4)
                begin
                    p     = '0;
                    phase = PH_TAG;
                end
            end
            PH_PAYLOAD:
            begin
                r.role       = ROLE_PAYLOAD;
                r.chunk_kind = kind_now;
                if (kind_now == KIND_ICON)
                    r.icon_number = icons - 16'd1;
                remaining = remaining - 32'd1;
                if (kind_now == KIND_ANIH)
                begin
                    word_sr = {it.data_byte, word_sr[31:8]};
                    p       = (p + 4'd1) & 4'd3;
                    if (p == 4'd0 && anih_fields < ANIH_FIELDS)
                    begin
                        anih_fields   = anih_fields + 4'd1;
                        r.word_done   = 1'b1;
                        r.word_value  = word_sr;
                        r.field_index = anih_fields;
                    end
                end
                if (remaining == '0)
                begin
                    r.payload_last = 1'b1;
                    p              = '0;
                    phase          = PH_TAG;
                end
            end
            default:
            begin
                phase  = PH_HEADER;
                r.role = ROLE_HEADER;
                if (p > HDR_LEN - 4'd1)
                    p = HDR_LEN - 4'd1;
                if (p >= HDR_LEN_FIRST && p <= HDR_LEN_LAST)
                begin
                    word_sr = {it.data_byte, word_sr[31:8]};
                    if (p == HDR_LEN_LAST)
                    begin
                        r.word_done  = 1'b1;
                        r.word_value = word_sr;
                    end
                end
                else if (it.data_byte != magic_at(p))
                    err = (p < HDR_LEN_FIRST) ? ERR_BAD_RIFF : ERR_BAD_ACON;
                p = p + 4'd1;
                if (p >= HDR_LEN)
                begin
                    p     = '0;
                    phase = PH_TAG;
                end
            end
        endcase
        pos = p;

        if (err == ERR_NONE && it.end_of_data)
        begin
            // a clean end sends the parser back to the start of a new file
            if (phase == PH_TAG && pos == '0)
            begin
                r.stream_end = 1'b1;
                clear_parser();
            end
            else
                err = ERR_TRUNCATED;
        end
        if (err != ERR_NONE)
        begin
            err_latched  = err;
            r            = '0;
            r.byte_out   = it.data_byte;
            r.role       = ROLE_ERROR;
            r.error_code = err;
        end
    endtask

    function automatic int field_check(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        int        bad;
        if (!rst_n)
        begin
            clear_parser();
            tagged_due.delete();
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            bad = 0;
            if (result_valid && result_ready)
            begin
                if (tagged_due.size() == 0)
                begin
                    $display("%0t: result expected none, got %0h", $time, result);
                    bad++;
                end
                else
                begin
                    want = tagged_due.pop_front();
                    bad += field_check("role",         want.role,         result.role);
                    bad += field_check("chunk_kind",   want.chunk_kind,   result.chunk_kind);
                    bad += field_check("byte_out",     want.byte_out,     result.byte_out);
                    bad += field_check("payload_last", want.payload_last, result.payload_last);
                    bad += field_check("icon_number",  want.icon_number,  result.icon_number);
                    bad += field_check("word_done",    want.word_done,    result.word_done);
                    bad += field_check("word_value",   want.word_value,   result.word_value);
                    bad += field_check("field_index",  want.field_index,  result.field_index);
                    bad += field_check("error_code",   want.error_code,   result.error_code);
                    bad += field_check("stream_end",   want.stream_end,   result.stream_end);
                end
            end
            if (item_valid && item_ready)
            begin
                tag_byte(item, want);
                tagged_due = {tagged_due, want};
            end
            failures    <= failures + bad;
            outstanding <= tagged_due.size();
        end
    end

endmodule

// ----- bench/riff_ani_chunk_parser_unit_tb.sv -----
// Testbench top for the RIFF chunk parser: clock, reset, byte-stream stimulus and verdict.
module riff_ani_chunk_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import racp_pkg::*;

    localparam logic [31:0] RIFF_ID      = 32'h5249_4646;
    localparam logic [31:0] ACON_ID      = 32'h4143_4F4E;
    localparam int          RANDOM_ITEMS = 1250;
    localparam int          ICON_RUN     = 8;
    localparam longint      CYCLE_LIMIT  = 200_000;

    localparam logic [31:0] KNOWN_TAGS [7] = '{TAG_INAM, TAG_IART, TAG_ICON, TAG_SEQ,
                                              TAG_RATE, TAG_ANIH, TAG_LIST};

    typedef enum logic [1:0] {
        CLOSE_BAD_RIFF,
        CLOSE_BAD_ACON,
        CLOSE_BAD_TAG,
        CLOSE_TRUNCATED
    } closing_t;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    in_item_t  item;
    logic      result_valid;
    logic      result_ready;
    out_item_t result;
    int        failures;
    int        outstanding;
    bit        gaps_on = 1'b0;
    int        sent    = 0;
    longint    cycles  = 0;

    riff_ani_chunk_parser_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    riff_ani_chunk_parser_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int hold;
        hold = 0;
        result_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (gaps_on && $urandom_range(0, 5) == 0)
                hold = $urandom_range(1, 6);
            result_ready <= (hold == 0);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eod);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 6);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{data_byte: b, end_of_data: eod};
        do
            @(posedge clk);
        while (!item_ready);
        sent++;
    endtask

    function automatic longint chunk_size(input logic [31:0] tag, input logic [31:0] len);
        return (tag == TAG_LIST) ? 64'd12 : 64'd8 + len;
    endfunction

    function automatic logic [31:0] pick_len(input logic [31:0] tag);
        if (tag == TAG_LIST)
            return $urandom;
        if (tag == TAG_ANIH)
            return $urandom_range(0, 44);
        if ($urandom_range(0, 3) == 0)
            return '0;
        return $urandom_range(1, 10);
    endfunction

    // eod_at / bad_at index a header byte, -1 for none
    task automatic send_header(input logic [31:0] len, input int eod_at, input int bad_at);
        logic [7:0] b;
        for (int i = 0; i < 12; i++)
        begin
            if (i < 4)
                b = RIFF_ID[31 - 8 * i -: 8];
            else if (i < 8)
                b = len[8 * (i - 4) +: 8];
            else
                b = ACON_ID[31 - 8 * (i - 8) -: 8];
            if (i == bad_at)
                b = b ^ 8'($urandom_range(1, 255));
            send_byte(b, i == eod_at);
        end
    endtask

    // tag, length, then list type or payload; the item stream stops at eod_at
    task automatic send_chunk(input logic [31:0] tag, input logic [31:0] len,
                              input longint eod_at);
        longint     stop;
        logic [7:0] b;
        stop = (eod_at >= 0) ? eod_at + 1 : chunk_size(tag, len);
        for (longint i = 0; i < stop; i++)
        begin
            if (i < 4)
                b = tag[31 - 8 * i -: 8];
            else if (i < 8)
                b = len[8 * (i - 4) +: 8];
            else if ($urandom_range(0, 7) == 0)
                b = {8{1'($urandom_range(0, 1))}};
            else
                b = 8'($urandom);
            send_byte(b, i == eod_at);
        end
    endtask

    task automatic send_file(input int nchunks, input bit closed);
        logic [31:0] tag;
        logic [31:0] len;
        send_header($urandom, (closed && nchunks == 0) ? 11 : -1, -1);
        for (int c = 0; c < nchunks; c++)
        begin
            tag = KNOWN_TAGS[$urandom_range(0, 6)];
            len = pick_len(tag);
            send_chunk(tag, len, (closed && c == nchunks - 1) ? chunk_size(tag, len) - 1 : -1);
        end
    endtask

    initial
    begin
        closing_t    closing;
        logic [31:0] tag;
        logic [31:0] len;
        longint      cut;

        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header-only file, then LIST, ICON, ANIH and RATE chunks with edge lengths
        send_header(32'hFFFF_FFFF, 11, -1);
        send_header(32'h0000_0000, -1, -1);
        send_chunk(TAG_LIST, 32'hFFFF_FFFF, -1);
        send_chunk(TAG_ICON, 32'd0, -1);
        send_chunk(TAG_ANIH, 32'd36, -1);
        send_chunk(TAG_LIST, 32'd0, -1);
        send_chunk(TAG_RATE, 32'd1, chunk_size(TAG_RATE, 32'd1) - 1);

        while (sent < RANDOM_ITEMS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            send_file(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                  : $urandom_range(3, 10), 1'b1);
        end

        // no idling from here on; a run of empty icon chunks
        gaps_on = 1'b0;
        send_header($urandom, -1, -1);
        for (int c = 0; c < ICON_RUN; c++)
            send_chunk(TAG_ICON, 32'd0, (c == ICON_RUN - 1) ? 7 : -1);

        // the closing file breaks the stream; the error then holds for the rest
        closing = closing_t'($urandom_range(0, 3));
        case (closing)
            CLOSE_BAD_RIFF:
                send_header($urandom, -1, $urandom_range(0, 3));
            CLOSE_BAD_ACON:
                send_header($urandom, -1, $urandom_range(8, 11));
            CLOSE_BAD_TAG:
            begin
                send_file($urandom_range(0, 4), 1'b0);
                tag = KNOWN_TAGS[$urandom_range(0, 6)]
                      ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
                send_chunk(tag, $urandom_range(0, 8), $urandom_range(0, 1) ? 3 : -1);
            end
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                    send_header($urandom, $urandom_range(0, 10), -1);
                else
                begin
                    send_file($urandom_range(0, 4), 1'b0);
                    tag = KNOWN_TAGS[$urandom_range(0, 6)];
                    if ($urandom_range(0, 1) == 0)
                    begin
                        len = $urandom | 32'd1;
                        cut = $urandom_range(0, 7);
                    end
                    else
                    begin
                        len = $urandom_range(2, 12);
                        cut = $urandom_range(8, (tag == TAG_LIST) ? 10 : 6 + len);
                    end
                    send_chunk(tag, len, cut);
                end
            end
        endcase
        repeat (40)
            send_byte($urandom, 1'($urandom_range(0, 1)));

        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- riff_ani_chunk_parser_unit.f -----
sv/racp_pkg.sv
sv/riff_ani_chunk_parser_unit.sv
bench/riff_ani_chunk_parser_checker.sv
bench/riff_ani_chunk_parser_unit_tb.sv
